FILE: sv/assert_macros.svh
// Assertion macros used by the checker module of the pad grid detector.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pgtd check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pgtd check failed");

`endif

FILE: sv/pgtd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the pad grid touch detector.
// Depends on nothing; every other file but assert_macros.svh imports it.
package pgtd_pkg;

  localparam int MAX_GRID   = 4;
  localparam int NPADS      = MAX_GRID * MAX_GRID;
  localparam int GIDX_W     = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
  localparam int GRID_W     = 3;
  localparam int PAD_W      = 4;
  localparam int CNT_W      = 5;
  localparam int COORD_W    = 15;
  localparam int EXT_W      = 14;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int COEF_W     = 5;
  localparam int PROD_W     = 21;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  typedef enum logic [1:0] {
    FUNC_POINT  = 2'd0,
    FUNC_FRAME  = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_UNUSED = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_TOUCH   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_MARK    = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    CFG_CENTRE_X = 3'd0,
    CFG_CENTRE_Y = 3'd1,
    CFG_CENTRE_Z = 3'd2,
    CFG_WIDTH    = 3'd3,
    CFG_HEIGHT   = 3'd4,
    CFG_DEPTH    = 3'd5,
    CFG_GRID_N   = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PT_MUL,
    ST_PT_HIT,
    ST_SCAN,
    ST_STATUS
  } state_e;

  typedef struct packed {
    logic clear_all;
    logic clear_touched;
    logic shift;
    logic mark_en;
  } cell_ctrl_t;

  typedef struct packed {
    logic [GIDX_W-1:0] row;
    logic [GIDX_W-1:0] col;
    logic              valid;
  } pad_pos_t;

  // Row and column of a pad id for a grid of n pads per side.
  function automatic pad_pos_t pad_pos(input logic [PAD_W-1:0] id,
                                       input logic [GRID_W-1:0] n);
    pad_pos_t p;
    p = '0;
    for (int r = 0; r < MAX_GRID; r++) begin
      for (int c = 0; c < MAX_GRID; c++) begin
        if (r < int'(n) && c < int'(n) && (r * int'(n) + c) == int'(id)) begin
          p.row   = GIDX_W'(r);
          p.col   = GIDX_W'(c);
          p.valid = 1'b1;
        end
      end
    end
    return p;
  endfunction

endpackage

FILE: sv/pad_grid_touch_detector.sv
`timescale 1ns / 1ps
// Top level of the pad grid touch detector: configuration registers, item
// sequencer, output register and the chain of pad cells.
// Depends on pgtd_pkg, pgtd_locate and pgtd_cell.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  func, point_x, point_y, point_z
//   out      output     out_valid_o/out_stall_i  event_kind, pad_index,
//                                              inside_box, active_count, last
//   cfg      input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// A point item passes the offset register, the multiply register, then
// compare and first-free pad search along the cell chain into the output.
// A frame end rotates the 16-cell chain once, one pad a cycle while the
// output is not stalled, then adds the status result.
// One item is in work at a time; the next transfer is taken the cycle after
// the item's last result enters the output register.
// Output stall holds the sequencer; reset empties the output register and
// clears all pad flags and the count.
module pad_grid_touch_detector (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic        [1:0]                      func_i,
  input  logic signed [pgtd_pkg::COORD_W-1:0]    point_x_i,
  input  logic signed [pgtd_pkg::COORD_W-1:0]    point_y_i,
  input  logic signed [pgtd_pkg::COORD_W-1:0]    point_z_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic        [1:0]                      event_kind_o,
  output logic        [pgtd_pkg::PAD_W-1:0]      pad_index_o,
  output logic                                   inside_box_o,
  output logic        [pgtd_pkg::CNT_W-1:0]      active_count_o,
  output logic                                   last_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic        [pgtd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [pgtd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pgtd_pkg::*;

  logic signed [COORD_W-1:0] centre_x_q, centre_y_q, centre_z_q;
  logic        [EXT_W-1:0]   box_width_q, box_height_q, box_depth_q;
  logic        [GRID_W-1:0]  grid_n_q;
  logic        [GRID_W-1:0]  n_eff;
  logic                      cfg_we, grid_clear;

  state_e                    state_q, state_d;
  func_e                     func_q;
  logic        [PAD_W-1:0]   scan_cnt_q, scan_cnt_d;
  logic        [CNT_W-1:0]   count_q, count_d;
  cell_ctrl_t                ctrl;
  logic                      in_acc, out_free, loc_load;

  logic                      out_valid_q;
  event_e                    out_kind_q, out_kind_d;
  logic        [PAD_W-1:0]   out_pad_q, out_pad_d;
  logic                      out_inside_q, out_inside_d;
  logic        [CNT_W-1:0]   out_count_q, out_count_d;
  logic                      out_last_q, out_last_d;
  logic                      out_load;

  logic                      loc_inside;
  logic        [MAX_GRID-1:0] col_hit, row_hit;

  logic        [NPADS-1:0]   touched, was, hit, mark;
  logic        [NPADS:0]     claim;
  logic        [PAD_W-1:0]   mark_id;
  logic                      any_mark;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign grid_clear  = cfg_we && (cfg_idx_e'(cfg_index_i) == CFG_GRID_N);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q   <= '0;
      centre_y_q   <= '0;
      centre_z_q   <= COORD_W'(1000);
      box_width_q  <= EXT_W'(1000);
      box_height_q <= EXT_W'(100);
      box_depth_q  <= EXT_W'(1000);
      grid_n_q     <= GRID_W'(MAX_GRID);
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CENTRE_X: centre_x_q   <= $signed(cfg_data_i[COORD_W-1:0]);
        CFG_CENTRE_Y: centre_y_q   <= $signed(cfg_data_i[COORD_W-1:0]);
        CFG_CENTRE_Z: centre_z_q   <= $signed(cfg_data_i[COORD_W-1:0]);
        CFG_WIDTH:    box_width_q  <= cfg_data_i[EXT_W-1:0];
        CFG_HEIGHT:   box_height_q <= cfg_data_i[EXT_W-1:0];
        CFG_DEPTH:    box_depth_q  <= cfg_data_i[EXT_W-1:0];
        CFG_GRID_N:   grid_n_q     <= cfg_data_i[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_n_q == '0) begin
      n_eff = GRID_W'(1);
    end else if (grid_n_q > GRID_W'(MAX_GRID)) begin
      n_eff = GRID_W'(MAX_GRID);
    end else begin
      n_eff = grid_n_q;
    end
  end

  pgtd_locate u_locate (
    .clk_i        (clk_i),
    .load_i       (loc_load),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .centre_x_i   (centre_x_q),
    .centre_y_i   (centre_y_q),
    .centre_z_i   (centre_z_q),
    .box_width_i  (box_width_q),
    .box_height_i (box_height_q),
    .box_depth_i  (box_depth_q),
    .grid_i       (n_eff),
    .inside_o     (loc_inside),
    .col_hit_o    (col_hit),
    .row_hit_o    (row_hit)
  );

  // Pad chain. Cell i shifts in from cell i+1; the last cell takes cell 0
  // with its was-touched flag set to its touched flag.
  assign claim[0] = 1'b0;

  for (genvar i = 0; i < NPADS; i++) begin : g_pad
    pad_pos_t pos;
    logic     nb_t, nb_w;

    assign pos    = pad_pos(PAD_W'(i), n_eff);
    assign hit[i] = loc_inside && pos.valid && row_hit[pos.row] && col_hit[pos.col];

    if (i == NPADS - 1) begin : g_wrap
      assign nb_t = touched[0];
      assign nb_w = touched[0];
    end else begin : g_link
      assign nb_t = touched[i+1];
      assign nb_w = was[i+1];
    end

    pgtd_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .nb_touched_i (nb_t),
      .nb_was_i     (nb_w),
      .hit_i        (hit[i]),
      .claim_i      (claim[i]),
      .touched_o    (touched[i]),
      .was_o        (was[i]),
      .claim_o      (claim[i+1]),
      .mark_o       (mark[i])
    );
  end

  assign any_mark = claim[NPADS];

  always_comb begin
    mark_id = '0;
    for (int i = 0; i < NPADS; i++) begin
      if (mark[i]) begin
        mark_id = mark_id | PAD_W'(i);
      end
    end
  end

  // Item sequencer.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      func_q     <= FUNC_POINT;
      scan_cnt_q <= '0;
      count_q    <= '0;
    end else begin
      state_q    <= state_d;
      scan_cnt_q <= scan_cnt_d;
      count_q    <= count_d;
      if (in_acc) begin
        func_q <= func_e'(func_i);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    scan_cnt_d   = scan_cnt_q;
    count_d      = count_q;
    ctrl         = '0;
    loc_load     = 1'b0;
    out_load     = 1'b0;
    out_kind_d   = EV_NONE;
    out_pad_d    = '0;
    out_inside_d = 1'b0;
    out_count_d  = count_q;
    out_last_d   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (func_e'(func_i))
            FUNC_POINT: begin
              loc_load = 1'b1;
              state_d  = ST_PT_MUL;
            end
            FUNC_FRAME: begin
              scan_cnt_d = '0;
              state_d    = ST_SCAN;
            end
            default: state_d = ST_STATUS;
          endcase
        end
      end
      ST_PT_MUL: begin
        state_d = ST_PT_HIT;
      end
      ST_PT_HIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_inside_d = loc_inside;
          out_last_d   = 1'b1;
          if (any_mark) begin
            ctrl.mark_en = 1'b1;
            count_d      = count_q + CNT_W'(1);
            out_kind_d   = EV_MARK;
            out_pad_d    = mark_id;
            out_count_d  = count_d;
          end
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          ctrl.shift = 1'b1;
          if (touched[0] != was[0]) begin
            out_load   = 1'b1;
            out_kind_d = touched[0] ? EV_TOUCH : EV_RELEASE;
            out_pad_d  = scan_cnt_q;
          end
          if (scan_cnt_q == PAD_W'(NPADS - 1)) begin
            state_d = ST_STATUS;
          end else begin
            scan_cnt_d = scan_cnt_q + PAD_W'(1);
          end
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last_d = 1'b1;
          if (func_q == FUNC_CLEAR) begin
            ctrl.clear_touched = 1'b1;
            count_d            = '0;
            out_count_d        = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (grid_clear) begin
      ctrl.clear_all = 1'b1;
      count_d        = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q   <= out_kind_d;
      out_pad_q    <= out_pad_d;
      out_inside_q <= out_inside_d;
      out_count_q  <= out_count_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = out_kind_q;
  assign pad_index_o    = out_pad_q;
  assign inside_box_o   = out_inside_q;
  assign active_count_o = out_count_q;
  assign last_o         = out_last_q;

endmodule

FILE: sv/pgtd_cell.sv
`timescale 1ns / 1ps
// One pad of the detector chain: touched and was-touched flags, the first-hit
// claim link and the shift link to the neighboring pad. Uses pgtd_pkg.
module pgtd_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pgtd_pkg::cell_ctrl_t ctrl_i,
  input  logic                 nb_touched_i,
  input  logic                 nb_was_i,
  input  logic                 hit_i,
  input  logic                 claim_i,
  output logic                 touched_o,
  output logic                 was_o,
  output logic                 claim_o,
  output logic                 mark_o
);
  import pgtd_pkg::*;

  logic touched_q, touched_d;
  logic was_q, was_d;

  assign mark_o  = hit_i & ~touched_q & ~claim_i;
  assign claim_o = claim_i | (hit_i & ~touched_q);

  always_comb begin
    touched_d = touched_q;
    was_d     = was_q;
    if (ctrl_i.clear_all) begin
      touched_d = 1'b0;
      was_d     = 1'b0;
    end else if (ctrl_i.clear_touched) begin
      touched_d = 1'b0;
    end else if (ctrl_i.shift) begin
      touched_d = nb_touched_i;
      was_d     = nb_was_i;
    end else if (ctrl_i.mark_en && mark_o) begin
      touched_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touched_q <= 1'b0;
      was_q     <= 1'b0;
    end else begin
      touched_q <= touched_d;
      was_q     <= was_d;
    end
  end

  assign touched_o = touched_q;
  assign was_o     = was_q;

endmodule

FILE: sv/pgtd_locate.sv
`timescale 1ns / 1ps
// Point locator: centre offset, box test and the doubled cross-multiplied
// cell bounds per grid column and row, two register stages. Uses pgtd_pkg.
module pgtd_locate (
  input  logic                                 clk_i,
  input  logic                                 load_i,
  input  logic signed [pgtd_pkg::COORD_W-1:0]  point_x_i,
  input  logic signed [pgtd_pkg::COORD_W-1:0]  point_y_i,
  input  logic signed [pgtd_pkg::COORD_W-1:0]  point_z_i,
  input  logic signed [pgtd_pkg::COORD_W-1:0]  centre_x_i,
  input  logic signed [pgtd_pkg::COORD_W-1:0]  centre_y_i,
  input  logic signed [pgtd_pkg::COORD_W-1:0]  centre_z_i,
  input  logic        [pgtd_pkg::EXT_W-1:0]    box_width_i,
  input  logic        [pgtd_pkg::EXT_W-1:0]    box_height_i,
  input  logic        [pgtd_pkg::EXT_W-1:0]    box_depth_i,
  input  logic        [pgtd_pkg::GRID_W-1:0]   grid_i,
  output logic                                 inside_o,
  output logic        [pgtd_pkg::MAX_GRID-1:0] col_hit_o,
  output logic        [pgtd_pkg::MAX_GRID-1:0] row_hit_o
);
  import pgtd_pkg::*;

  localparam int TWO_W = DIFF_W + 2;

  logic signed [DIFF_W-1:0] dx_q, dy_q, dz_q;
  logic signed [PROD_W-1:0] vx_q, vz_q;
  logic signed [PROD_W-1:0] lo_x_q [MAX_GRID];
  logic signed [PROD_W-1:0] hi_x_q [MAX_GRID];
  logic signed [PROD_W-1:0] lo_z_q [MAX_GRID];
  logic signed [PROD_W-1:0] hi_z_q [MAX_GRID];
  logic                     inside_q;

  logic signed [TWO_W-1:0]  tx, ty, tz, wx, wy, wz;
  logic signed [COEF_W-1:0] two_n;
  logic signed [PROD_W-1:0] ext_x, ext_z;
  logic                     inside_d;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dx_q <= DIFF_W'(point_x_i) - DIFF_W'(centre_x_i);
      dy_q <= DIFF_W'(point_y_i) - DIFF_W'(centre_y_i);
      dz_q <= DIFF_W'(point_z_i) - DIFF_W'(centre_z_i);
    end
  end

  assign tx = $signed({dx_q[DIFF_W-1], dx_q, 1'b0});
  assign ty = $signed({dy_q[DIFF_W-1], dy_q, 1'b0});
  assign tz = $signed({dz_q[DIFF_W-1], dz_q, 1'b0});
  assign wx = $signed({{(TWO_W-EXT_W){1'b0}}, box_width_i});
  assign wy = $signed({{(TWO_W-EXT_W){1'b0}}, box_height_i});
  assign wz = $signed({{(TWO_W-EXT_W){1'b0}}, box_depth_i});

  assign inside_d = (tx > -wx) && (tx < wx) && (ty > -wy) && (ty < wy) &&
                    (tz > -wz) && (tz < wz);

  assign two_n = $signed({{(COEF_W-GRID_W-1){1'b0}}, grid_i, 1'b0});
  assign ext_x = $signed({{(PROD_W-EXT_W){1'b0}}, box_width_i});
  assign ext_z = $signed({{(PROD_W-EXT_W){1'b0}}, box_depth_i});

  always_ff @(posedge clk_i) begin
    inside_q <= inside_d;
    vx_q     <= PROD_W'(two_n) * PROD_W'(dx_q);
    vz_q     <= PROD_W'(two_n) * PROD_W'(dz_q);
  end

  for (genvar c = 0; c < MAX_GRID; c++) begin : g_bound
    logic signed [COEF_W-1:0] coef_lo, coef_hi;

    assign coef_lo = $signed(COEF_W'(2 * c)) - $signed({2'b00, grid_i});
    assign coef_hi = $signed(COEF_W'(2 * c + 2)) - $signed({2'b00, grid_i});

    always_ff @(posedge clk_i) begin
      lo_x_q[c] <= PROD_W'(coef_lo) * ext_x;
      hi_x_q[c] <= PROD_W'(coef_hi) * ext_x;
      lo_z_q[c] <= PROD_W'(coef_lo) * ext_z;
      hi_z_q[c] <= PROD_W'(coef_hi) * ext_z;
    end

    assign col_hit_o[c] = (vx_q >= lo_x_q[c]) && (vx_q <= hi_x_q[c]);
    assign row_hit_o[c] = (vz_q >= lo_z_q[c]) && (vz_q <= hi_z_q[c]);
  end

  assign inside_o = inside_q;

endmodule

FILE: sv/pgtd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the pad grid touch detector, bound to the top level.
// Depends on pgtd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pgtd_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_stall_o,
  input logic        [1:0]                      func_i,
  input logic signed [pgtd_pkg::COORD_W-1:0]    point_x_i,
  input logic signed [pgtd_pkg::COORD_W-1:0]    point_y_i,
  input logic signed [pgtd_pkg::COORD_W-1:0]    point_z_i,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic        [1:0]                      event_kind_o,
  input logic        [pgtd_pkg::PAD_W-1:0]      pad_index_o,
  input logic                                   inside_box_o,
  input logic        [pgtd_pkg::CNT_W-1:0]      active_count_o,
  input logic                                   last_o,
  input logic                                   cfg_valid_i,
  input logic                                   cfg_ready_o,
  input logic        [pgtd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic        [pgtd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pgtd_pkg::*;

  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(event_kind_o) && $stable(pad_index_o) && $stable(active_count_o) && $stable(last_o))
  `ASSERT_IMPL(a_mark_inside, out_valid_o && event_kind_o == EV_MARK, inside_box_o && last_o)
  `ASSERT_IMPL(a_edge_mid, out_valid_o && (event_kind_o == EV_TOUCH || event_kind_o == EV_RELEASE), !last_o && !inside_box_o)
  `ASSERT_IMPL(a_status_last, out_valid_o && event_kind_o == EV_NONE, pad_index_o == '0 && last_o)
  `ASSERT_IMPL(a_count_range, out_valid_o, active_count_o <= CNT_W'(NPADS))

endmodule

bind pad_grid_touch_detector pgtd_checker u_pgtd_checker (.*);

FILE: test/pad_grid_touch_detector_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of pad_grid_touch_detector: directed rows, then random
// phases under several register settings, checked against an in-bench pad model.
// Depends on pgtd_pkg and the detector RTL.
module pad_grid_touch_detector_tb;
  import pgtd_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 50;
  localparam logic [CFG_IDX_W-1:0] CFG_UNLISTED = 3'd7;

  typedef struct packed {
    event_e             kind;
    logic [PAD_W-1:0]   pad;
    logic               in_box;
    logic [CNT_W-1:0]   count;
    logic               last;
  } pad_event_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    func_e                 f;
    int                    x, y, z;
    bit                    typed;
    pad_event_t            want;
  } dir_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [1:0]                     func_i = FUNC_POINT;
  logic signed [COORD_W-1:0]      point_x_i = '0;
  logic signed [COORD_W-1:0]      point_y_i = '0;
  logic signed [COORD_W-1:0]      point_z_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [1:0]                     event_kind_o;
  logic [PAD_W-1:0]               pad_index_o;
  logic                           inside_box_o;
  logic [CNT_W-1:0]               active_count_o;
  logic                           last_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [CFG_IDX_W-1:0]           cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]          cfg_data_i = '0;

  pad_grid_touch_detector dut (.*);

  always #4 clk_i = ~clk_i;

  // Pad model state and register copies.
  int              ctr_x = 0, ctr_y = 0, ctr_z = 1000;
  int              ext_w = 1000, ext_h = 100, ext_d = 1000;
  int              grid_reg = MAX_GRID;
  bit [NPADS-1:0]  pad_hit = '0;
  bit [NPADS-1:0]  pad_prev = '0;
  int              hit_count = 0;

  pad_event_t      step_events[$];
  pad_event_t      pending_events[$];
  dir_row_t        dir_rows[$];
  int              errors = 0;
  int              cycle_count = 0;
  int              hold_req = 0;
  bit              idle_on = 1'b1;

  function automatic int grid_eff();
    if (grid_reg < 1) return 1;
    if (grid_reg > MAX_GRID) return MAX_GRID;
    return grid_reg;
  endfunction

  function automatic bit cell_hit(int d, int e, int c, int n);
    int v;
    v = 2 * n * d;
    return v >= (2 * c - n) * e && v <= (2 * c + 2 - n) * e;
  endfunction

  function automatic pad_event_t make_event(event_e k, int pad, bit ins, bit lst);
    pad_event_t ev;
    ev.kind   = k;
    ev.pad    = PAD_W'(pad);
    ev.in_box = ins;
    ev.count  = CNT_W'(hit_count);
    ev.last   = lst;
    return ev;
  endfunction

  function automatic void model_config(logic [CFG_IDX_W-1:0] idx,
                                       logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_CENTRE_X: ctr_x = int'(signed'(data));
      CFG_CENTRE_Y: ctr_y = int'(signed'(data));
      CFG_CENTRE_Z: ctr_z = int'(signed'(data));
      CFG_WIDTH:    ext_w = int'(data[EXT_W-1:0]);
      CFG_HEIGHT:   ext_h = int'(data[EXT_W-1:0]);
      CFG_DEPTH:    ext_d = int'(data[EXT_W-1:0]);
      CFG_GRID_N: begin
        grid_reg  = int'(data[GRID_W-1:0]);
        pad_hit   = '0;
        pad_prev  = '0;
        hit_count = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic void model_item(func_e f, logic signed [COORD_W-1:0] px,
                                     logic signed [COORD_W-1:0] py,
                                     logic signed [COORD_W-1:0] pz);
    int n, dx, dy, dz, id;
    bit ins, done;
    step_events.delete();
    n = grid_eff();
    case (f)
      FUNC_POINT: begin
        dx = int'(px) - ctr_x;
        dy = int'(py) - ctr_y;
        dz = int'(pz) - ctr_z;
        ins = 2 * dx > -ext_w && 2 * dx < ext_w && 2 * dy > -ext_h && 2 * dy < ext_h &&
              2 * dz > -ext_d && 2 * dz < ext_d;
        done = 1'b0;
        if (ins) begin
          for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
              id = r * n + c;
              if (!done && !pad_hit[id] && cell_hit(dx, ext_w, c, n) &&
                  cell_hit(dz, ext_d, r, n)) begin
                pad_hit[id] = 1'b1;
                hit_count++;
                step_events = {step_events, make_event(EV_MARK, id, 1'b1, 1'b1)};
                done = 1'b1;
              end
            end
          end
        end
        if (!done) step_events = {step_events, make_event(EV_NONE, 0, ins, 1'b1)};
      end
      FUNC_FRAME: begin
        for (int i = 0; i < n * n; i++) begin
          if (pad_hit[i] && !pad_prev[i])
            step_events = {step_events, make_event(EV_TOUCH, i, 1'b0, 1'b0)};
          else if (!pad_hit[i] && pad_prev[i])
            step_events = {step_events, make_event(EV_RELEASE, i, 1'b0, 1'b0)};
          pad_prev[i] = pad_hit[i];
        end
        step_events = {step_events, make_event(EV_NONE, 0, 1'b0, 1'b1)};
      end
      default: begin
        if (f == FUNC_CLEAR) begin
          pad_hit   = '0;
          hit_count = 0;
        end
        step_events = {step_events, make_event(EV_NONE, 0, 1'b0, 1'b1)};
      end
    endcase
  endfunction

  // Centre offset inside the box if ext >= 1; with edges, often on a cell edge.
  function automatic int box_offset(int ext, bit edges);
    int half, v, c, n;
    if (ext < 1) return int'($urandom_range(0, 600)) - 300;
    half = (ext - 1) / 2;
    n = grid_eff();
    if (edges && $urandom_range(0, 1)) begin
      c = $urandom_range(0, n);
      v = ((2 * c - n) * ext) / (2 * n) + int'($urandom_range(0, 2)) - 1;
    end else begin
      v = int'($urandom_range(0, 2 * half)) - half;
    end
    if (v > half) v = half;
    if (v < -half) v = -half;
    return v;
  endfunction

  function automatic void add_item(func_e f, int x, int y, int z);
    dir_row_t r;
    r.is_cfg   = 1'b0;
    r.reg_idx  = '0;
    r.reg_data = '0;
    r.f        = f;
    r.x        = x;
    r.y        = y;
    r.z        = z;
    r.typed    = 1'b0;
    r.want     = '0;
    dir_rows = {dir_rows, r};
  endfunction

  function automatic void add_check(func_e f, int x, int y, int z, event_e k, int pad,
                                    bit ins, int cnt);
    add_item(f, x, y, z);
    dir_rows[$].typed       = 1'b1;
    dir_rows[$].want.kind   = k;
    dir_rows[$].want.pad    = PAD_W'(pad);
    dir_rows[$].want.in_box = ins;
    dir_rows[$].want.count  = CNT_W'(cnt);
    dir_rows[$].want.last   = 1'b1;
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, int data);
    add_item(FUNC_POINT, 0, 0, 0);
    dir_rows[$].is_cfg   = 1'b1;
    dir_rows[$].reg_idx  = idx;
    dir_rows[$].reg_data = CFG_DATA_W'(data);
  endfunction

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    model_config(idx, data);
  endtask

  task automatic send_item(func_e f, logic signed [COORD_W-1:0] x,
                           logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z,
                           bit typed, pad_event_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    point_x_i  <= x;
    point_y_i  <= y;
    point_z_i  <= z;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    model_item(f, x, y, z);
    if (typed) pending_events = {pending_events, want};
    else pending_events = {pending_events, step_events};
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: checks every transfer and drives the stall pattern.
  initial begin
    pad_event_t got, want;
    int burst_left, hold_left, hold_seen;
    burst_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got = {event_kind_o, pad_index_o, inside_box_o, active_count_o, last_o};
        if (pending_events.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected transfer: kind %0d pad %0d in %0b cnt %0d last %0b",
                     got.kind, got.pad, got.in_box, got.count, got.last);
        end else begin
          want = pending_events.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: want kind %0d pad %0d in %0b cnt %0d last %0b,",
                       want.kind, want.pad, want.in_box, want.count, want.last,
                       " got kind %0d pad %0d in %0b cnt %0d last %0b",
                       got.kind, got.pad, got.in_box, got.count, got.last);
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(1, 19) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int setting[7];
    int pick;
    logic [CFG_DATA_W-1:0] data;
    logic signed [COORD_W-1:0] x, y, z;
    func_e f;

    add_check(FUNC_POINT, 0, 0, 1000, EV_MARK, 5, 1'b1, 1);
    add_check(FUNC_POINT, 16383, 0, 1000, EV_NONE, 0, 1'b0, 1);
    add_check(FUNC_POINT, -16384, -16384, -16384, EV_NONE, 0, 1'b0, 1);
    add_check(FUNC_POINT, 0, 16383, 16383, EV_NONE, 0, 1'b0, 1);
    add_item(FUNC_POINT, 0, 0, 1000);
    add_item(FUNC_POINT, -499, 0, 501);
    add_item(FUNC_POINT, 499, 49, 1499);
    add_item(FUNC_POINT, 500, 0, 1000);
    add_item(FUNC_POINT, 0, -50, 1000);
    add_item(FUNC_POINT, 250, 0, 1250);
    add_item(FUNC_FRAME, 0, 0, 0);
    add_item(FUNC_FRAME, 0, 0, 0);
    add_check(FUNC_CLEAR, 0, 0, 0, EV_NONE, 0, 1'b0, 0);
    add_item(FUNC_FRAME, 0, 0, 0);
    add_check(FUNC_UNUSED, 16383, 16383, 16383, EV_NONE, 0, 1'b0, 0);
    add_cfg(CFG_GRID_N, 0);
    add_check(FUNC_POINT, 0, 0, 1000, EV_MARK, 0, 1'b1, 1);
    add_item(FUNC_POINT, 0, 0, 1000);
    add_item(FUNC_FRAME, 0, 0, 0);
    add_cfg(CFG_GRID_N, 7);
    add_check(FUNC_POINT, -499, 0, 501, EV_MARK, 0, 1'b1, 1);
    add_cfg(CFG_WIDTH, 0);
    add_check(FUNC_POINT, 0, 0, 1000, EV_NONE, 0, 1'b0, 1);
    add_cfg(CFG_UNLISTED, 32767);
    add_cfg(CFG_WIDTH, 1000);
    add_cfg(CFG_HEIGHT, 0);
    add_item(FUNC_POINT, 0, 0, 1000);
    add_cfg(CFG_HEIGHT, 100);
    add_cfg(CFG_DEPTH, 0);
    add_item(FUNC_POINT, 0, 0, 1000);
    add_item(FUNC_FRAME, 0, 0, 0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
      else
        send_item(dir_rows[i].f, COORD_W'(dir_rows[i].x), COORD_W'(dir_rows[i].y),
                  COORD_W'(dir_rows[i].z), dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: setting = '{-16384, -16384, -16384, 16383, 16383, 16383, MAX_GRID};
        1: setting = '{16383, 16383, 16383, 1, 1, 1, 1};
        PHASES - 1: setting = '{0, 0, 1000, 1000, 100, 1000, MAX_GRID};
        default: begin
          for (int i = int'(CFG_CENTRE_X); i <= int'(CFG_CENTRE_Z); i++)
            setting[i] = int'($urandom_range(0, 4000)) - 2000;
          for (int i = int'(CFG_WIDTH); i <= int'(CFG_DEPTH); i++)
            setting[i] = $urandom_range(0, 1) ? 8 * $urandom_range(1, 500)
                                              : $urandom_range(1, 16383);
          setting[CFG_GRID_N] = (ph == 2) ? 2 : (ph == 3) ? 3 : $urandom_range(0, 7);
        end
      endcase
      idle_on = (ph < PHASES - 2);
      for (int i = int'(CFG_CENTRE_X); i <= int'(CFG_GRID_N); i++) begin
        data = CFG_DATA_W'(setting[i]);
        if (i >= int'(CFG_WIDTH)) data[CFG_DATA_W-1] = $urandom_range(0, 1);
        if (i == int'(CFG_GRID_N)) data[CFG_DATA_W-1:GRID_W] = $urandom;
        write_reg(cfg_idx_e'(i), data);
      end
      if (ph == 4) write_reg(CFG_UNLISTED, CFG_DATA_W'($urandom));
      if (ph == 2) hold_req++;

      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        x = COORD_W'($urandom);
        y = COORD_W'($urandom);
        z = COORD_W'($urandom);
        if (pick < 70) begin
          f = FUNC_POINT;
          x = COORD_W'(ctr_x + box_offset(ext_w, 1'b1));
          y = COORD_W'(ctr_y + box_offset(ext_h, 1'b0));
          z = COORD_W'(ctr_z + box_offset(ext_d, 1'b1));
        end else if (pick < 80) begin
          f = FUNC_POINT;
        end else if (pick < 90) begin
          f = FUNC_FRAME;
        end else if (pick < 96) begin
          f = FUNC_CLEAR;
        end else begin
          f = FUNC_UNUSED;
        end
        send_item(f, x, y, z, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
